// ----- rtl/ampt_pkg.sv -----
// Shared constants, types and register codes of the time-axis peak projection block.
package ampt_pkg;

   // Plane store geometry.
   localparam int MAX_X = 256;
   localparam int MAX_Y = 256;
   localparam int STORE_DEPTH = MAX_X * MAX_Y;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

   // Largest usable row and plane sizes.
   localparam logic [8:0] NX_MAX = 9'(MAX_X < 256 ? MAX_X : 256);
   localparam logic [8:0] NY_MAX = 9'(MAX_Y < 256 ? MAX_Y : 256);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CFG_SIZE_X  = 2'd0,
      CFG_SIZE_Y  = 2'd1,
      CFG_SAMPLES = 2'd2,
      CFG_SLICES  = 2'd3
   } cfg_index_type;

   // Register values after reset.
   localparam logic [8:0]  SIZE_X_RESET  = 9'd256;
   localparam logic [8:0]  SIZE_Y_RESET  = 9'd256;
   localparam logic [15:0] SAMPLES_RESET = 16'd1024;
   localparam logic [15:0] SLICES_RESET  = 16'd1;

   // One classified sample, as the front hands it to the back.
   typedef struct packed {
      logic [STORE_ADDR_W-1:0] addr;
      logic [15:0]             mag;
      logic                    first;
      logic                    t_last;
      logic                    last_vol;
      logic [7:0]              x;
      logic [7:0]              y;
      logic [15:0]             z;
   } entry_type;

endpackage

// ----- rtl/ampt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ampt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ampt_front.sv -----
// Front part: size registers, sample counters and classification of each sample.
module ampt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ampt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ampt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ampt_pkg::CSR_DATA_W-1:0]     prdata,
   input  logic                                req_valid,
   input  logic [15:0]                         req_sample,
   input  logic                                queue_full,
   output logic                                req_ready,
   output logic                                push,
   output ampt_pkg::entry_type                 push_entry
);
   import ampt_pkg::*;

   logic [8:0]  size_x_ff, size_x_in;
   logic [8:0]  size_y_ff, size_y_in;
   logic [15:0] samples_ff, samples_in;
   logic [15:0] slices_ff, slices_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [15:0] t_ff, t_in;
   logic [15:0] z_ff, z_in;

   logic [8:0]  nx;
   logic [8:0]  ny;
   logic [15:0] nt;
   logic [15:0] nz;
   logic        x_last;
   logic        y_last;
   logic        t_last;
   logic        z_last;
   logic        csr_write;
   cfg_index_type csr_index;

   assign csr_index = cfg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   // Register writes take effect at the access phase of the transfer.
   always_comb begin
      size_x_in  = size_x_ff;
      size_y_in  = size_y_ff;
      samples_in = samples_ff;
      slices_in  = slices_ff;
      if (csr_write) begin
         unique case (csr_index)
            CFG_SIZE_X:  size_x_in  = pwdata[8:0];
            CFG_SIZE_Y:  size_y_in  = pwdata[8:0];
            CFG_SAMPLES: samples_in = pwdata[15:0];
            CFG_SLICES:  slices_in  = pwdata[15:0];
            default:     size_x_in  = size_x_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         CFG_SIZE_X:  prdata = CSR_DATA_W'(size_x_ff);
         CFG_SIZE_Y:  prdata = CSR_DATA_W'(size_y_ff);
         CFG_SAMPLES: prdata = CSR_DATA_W'(samples_ff);
         CFG_SLICES:  prdata = CSR_DATA_W'(slices_ff);
         default:     prdata = '0;
      endcase
   end

   // Sizes in use, clamped to their legal ranges.
   always_comb begin
      nx = (size_x_ff == 9'd0) ? 9'd1 : ((size_x_ff > NX_MAX) ? NX_MAX : size_x_ff);
      ny = (size_y_ff == 9'd0) ? 9'd1 : ((size_y_ff > NY_MAX) ? NY_MAX : size_y_ff);
      nt = (samples_ff == 16'd0) ? 16'd1 : samples_ff;
      nz = (slices_ff == 16'd0) ? 16'd1 : slices_ff;
   end

   // A counter at or past its size counts as being at its last position.
   assign x_last = ({1'b0, x_ff} + 9'd1) >= nx;
   assign y_last = ({1'b0, y_ff} + 9'd1) >= ny;
   assign t_last = ({1'b0, t_ff} + 17'd1) >= {1'b0, nt};
   assign z_last = ({1'b0, z_ff} + 17'd1) >= {1'b0, nz};

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // Classify the sample at the head of the input channel.
   always_comb begin
      push_entry.addr     = STORE_ADDR_W'(32'(y_ff) * MAX_X + 32'(x_ff));
      push_entry.mag      = req_sample[15] ? 16'(~req_sample + 16'd1) : req_sample;
      push_entry.first    = (t_ff == 16'd0);
      push_entry.t_last   = t_last;
      push_entry.last_vol = x_last && y_last && z_last;
      push_entry.x        = x_ff;
      push_entry.y        = y_ff;
      push_entry.z        = z_ff;
   end

   // Nested counters: x fastest, then y, then time, then z.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      t_in = t_ff;
      z_in = z_ff;
      if (push) begin
         if (!x_last) begin
            x_in = x_ff + 8'd1;
         end else begin
            x_in = '0;
            if (!y_last) begin
               y_in = y_ff + 8'd1;
            end else begin
               y_in = '0;
               if (!t_last) begin
                  t_in = t_ff + 16'd1;
               end else begin
                  t_in = '0;
                  z_in = z_last ? 16'd0 : z_ff + 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= SIZE_X_RESET;
         size_y_ff  <= SIZE_Y_RESET;
         samples_ff <= SAMPLES_RESET;
         slices_ff  <= SLICES_RESET;
         x_ff       <= '0;
         y_ff       <= '0;
         t_ff       <= '0;
         z_ff       <= '0;
      end else begin
         size_x_ff  <= size_x_in;
         size_y_ff  <= size_y_in;
         samples_ff <= samples_in;
         slices_ff  <= slices_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         t_ff       <= t_in;
         z_ff       <= z_in;
      end
   end

endmodule

// ----- rtl/ampt_fifo.sv -----
// Short queue of classified samples between the front and the back.
module ampt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ampt_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ampt_pkg::entry_type head_entry
);
   import ampt_pkg::*;

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/ampt_back.sv -----
// Back part: read-modify-write of the plane store and the result register.
module ampt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ampt_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_pos_x,
   output logic [7:0]          rsp_pos_y,
   output logic [15:0]         rsp_pos_z,
   output logic [15:0]         rsp_peak,
   output logic                rsp_last_of_volume
);
   import ampt_pkg::*;

   logic      b1_valid_ff, b1_valid_in;
   entry_type b1_entry_ff;
   logic      b1_fwd_ff;
   logic [15:0] b1_fwd_data_ff;
   logic      b1_go;
   logic [15:0] rd_data;
   logic [15:0] old_peak;
   logic [15:0] cur_peak;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  pos_x_ff;
   logic [7:0]  pos_y_ff;
   logic [15:0] pos_z_ff;
   logic [15:0] peak_ff;
   logic        last_vol_ff;

   ampt_ram #(
      .WIDTH (16),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (b1_go),
      .wr_addr (b1_entry_ff.addr),
      .wr_data (cur_peak),
      .rd_en   (pop),
      .rd_addr (head_entry.addr),
      .rd_data (rd_data)
   );

   // The update stage moves on unless its result would overwrite one not yet taken.
   assign b1_go = b1_valid_ff && (!b1_entry_ff.t_last || !rsp_valid_ff || rsp_ready);
   assign pop   = head_valid && (!b1_valid_ff || b1_go);

   // Running maximum; a write to the same entry in the cycle of the read is forwarded.
   always_comb begin
      old_peak = b1_fwd_ff ? b1_fwd_data_ff : rd_data;
      if (b1_entry_ff.first || (b1_entry_ff.mag > old_peak)) begin
         cur_peak = b1_entry_ff.mag;
      end else begin
         cur_peak = old_peak;
      end
   end

   always_comb begin
      b1_valid_in = b1_valid_ff;
      if (pop) begin
         b1_valid_in = 1'b1;
      end else if (b1_go) begin
         b1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (b1_go && b1_entry_ff.t_last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the update stage, loaded together with the store read.
   always_ff @(posedge clock) begin
      if (pop) begin
         b1_entry_ff    <= head_entry;
         b1_fwd_ff      <= b1_go && (b1_entry_ff.addr == head_entry.addr);
         b1_fwd_data_ff <= cur_peak;
      end
   end

   // Result register for the transfer on the output channel.
   always_ff @(posedge clock) begin
      if (b1_go && b1_entry_ff.t_last) begin
         pos_x_ff    <= b1_entry_ff.x;
         pos_y_ff    <= b1_entry_ff.y;
         pos_z_ff    <= b1_entry_ff.z;
         peak_ff     <= cur_peak;
         last_vol_ff <= b1_entry_ff.last_vol;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = pos_x_ff;
   assign rsp_pos_y          = pos_y_ff;
   assign rsp_pos_z          = pos_z_ff;
   assign rsp_peak           = peak_ff;
   assign rsp_last_of_volume = last_vol_ff;

endmodule

// ----- rtl/abs_max_projection_time_top.sv -----
// Top level of the time-axis peak projection block.
//
// Samples arrive on the req_ channel one per transfer, in memory order: x fastest,
// then y, then time, then z. For each voxel the block keeps the largest absolute
// sample over time in a 64K-entry plane store and, on the last time sample, sends
// one rsp_ transfer with the voxel coordinates, the peak and an end-of-volume flag.
// Samples that are not the last of their trace give no transfer.
// The four size registers sit on the APB-style port at byte addresses 0, 4, 8, 12;
// the user must see they are written only while the block is idle; not enforced.
// A sample passes through the queue and the update stage into the result register,
// more slowly while the queue holds older samples. Intake is one sample per cycle
// while no result stalls, set by the single read-modify-write of the plane store
// per sample; a same-entry update in consecutive cycles is forwarded.
// A four-entry queue separates sample intake from the store update, so intake goes
// on while a result waits; when the receiver stalls, the update stage holds and the
// queue fills, after which req_ready drops.
// Reset clears the counters, the queue and the result register and restores the
// register defaults; the plane store is not cleared, each entry is written on the
// first time sample before it is read.
module abs_max_projection_time_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ampt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ampt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ampt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [15:0]                     req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_pos_x,
   output logic [7:0]                      rsp_pos_y,
   output logic [15:0]                     rsp_pos_z,
   output logic [15:0]                     rsp_peak,
   output logic                            rsp_last_of_volume
);
   import ampt_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   assign pready = 1'b1;

   ampt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .queue_full (queue_full),
      .req_ready  (req_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   ampt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ampt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_pos_z          (rsp_pos_z),
      .rsp_peak           (rsp_peak),
      .rsp_last_of_volume (rsp_last_of_volume)
   );

endmodule

// ----- rtl/ampt_chk.sv -----
// Port-level checker of the time-axis peak projection block and its bind.
module ampt_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [ampt_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [ampt_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [ampt_pkg::CSR_DATA_W-1:0] prdata,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_pos_x,
   input logic [7:0]                      rsp_pos_y,
   input logic [15:0]                     rsp_pos_z,
   input logic [15:0]                     rsp_peak,
   input logic                            rsp_last_of_volume
);
   import ampt_pkg::*;

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result transfer holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak) && $stable(rsp_pos_x)
         && $stable(rsp_pos_y) && $stable(rsp_pos_z) && $stable(rsp_last_of_volume))
      else $error("result changed while stalled");

   // A peak is an absolute 16-bit signed value.
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak <= 16'h8000)
      else $error("peak out of range");

   // A row size write reads back at once.
   a_size_x_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (paddr[3:2] == CFG_SIZE_X)
      |=> (paddr[3:2] != CFG_SIZE_X) || (prdata == CSR_DATA_W'($past(pwdata[8:0]))))
      else $error("row size read-back mismatch");

endmodule

bind abs_max_projection_time_top ampt_chk u_chk (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the time-axis peak projection block.
module tb;
   import ampt_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned RANDOM_ITEMS  = 280;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned REPORT_LIMIT  = 100;
   localparam int unsigned QUIET_FROM    = 400;
   localparam int unsigned QUIET_TO      = 800;

   // One finished voxel as it appears on the rsp_ channel.
   typedef struct packed {
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic [15:0] pos_z;
      logic [15:0] peak;
      logic        last_of_volume;
   } voxel_peak_type;

   // Tracks the voxel counters and plane store, and holds the peaks still to come.
   class peak_projection_checker;
      logic [8:0]     size_x;
      logic [8:0]     size_y;
      logic [15:0]    samples_per_trace;
      logic [15:0]    slices_z;
      int unsigned    x_pos;
      int unsigned    y_pos;
      int unsigned    t_pos;
      int unsigned    z_pos;
      logic [15:0]    plane [STORE_DEPTH];
      voxel_peak_type peaks_due[$];
      int unsigned    failures;

      function new();
         size_x = SIZE_X_RESET;
         size_y = SIZE_Y_RESET;
         samples_per_trace = SAMPLES_RESET;
         slices_z = SLICES_RESET;
         x_pos = 0;
         y_pos = 0;
         t_pos = 0;
         z_pos = 0;
         failures = 0;
      endfunction

      function void set_register(cfg_index_type index, logic [31:0] value);
         case (index)
            CFG_SIZE_X:  size_x = value[8:0];
            CFG_SIZE_Y:  size_y = value[8:0];
            CFG_SAMPLES: samples_per_trace = value[15:0];
            CFG_SLICES:  slices_z = value[15:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(int unsigned value, int unsigned hi);
         if (value < 1) return 1;
         if (value > hi) return hi;
         return value;
      endfunction

      // Folds one accepted sample into the store and queues a peak on the last time sample.
      function void note_sample(logic [15:0] sample);
         int unsigned    nx;
         int unsigned    ny;
         int unsigned    nt;
         int unsigned    nz;
         int unsigned    addr;
         int unsigned    magnitude;
         int unsigned    peak;
         bit             x_end;
         bit             y_end;
         bit             t_end;
         bit             z_end;
         voxel_peak_type due;
         nx = clamp_size(size_x, NX_MAX);
         ny = clamp_size(size_y, NY_MAX);
         nt = clamp_size(samples_per_trace, 65535);
         nz = clamp_size(slices_z, 65535);
         magnitude = sample[15] ? 32'h10000 - sample : sample;

         // The first time sample overwrites the entry, later ones keep the larger value.
         addr = (y_pos % MAX_Y) * MAX_X + (x_pos % MAX_X);
         peak = magnitude;
         if (t_pos != 0 && plane[addr] > peak) peak = plane[addr];
         plane[addr] = peak[15:0];

         x_end = x_pos + 1 >= nx;
         y_end = y_pos + 1 >= ny;
         t_end = t_pos + 1 >= nt;
         z_end = z_pos + 1 >= nz;
         if (t_end) begin
            due.pos_x = x_pos[7:0];
            due.pos_y = y_pos[7:0];
            due.pos_z = z_pos[15:0];
            due.peak = peak[15:0];
            due.last_of_volume = x_end && y_end && z_end;
            peaks_due.push_back(due);
         end

         // Counters advance x first, then y, then time, then z; a counter past its size wraps.
         if (!x_end) begin
            x_pos++;
         end else begin
            x_pos = 0;
            if (!y_end) begin
               y_pos++;
            end else begin
               y_pos = 0;
               if (!t_end) begin
                  t_pos++;
               end else begin
                  t_pos = 0;
                  z_pos = z_end ? 0 : z_pos + 1;
               end
            end
         end
      endfunction

      function void report(string text);
         failures++;
         if (failures <= REPORT_LIMIT) $error("%s", text);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) report($sformatf("%s: expected %0d, got %0d", name, want, got));
      endfunction

      function void check_result(voxel_peak_type got);
         voxel_peak_type want;
         if (peaks_due.size() == 0) begin
            report($sformatf("result transfer with nothing due: x=%0d y=%0d z=%0d peak=%0d",
                             got.pos_x, got.pos_y, got.pos_z, got.peak));
            return;
         end
         want = peaks_due.pop_front();
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("pos_z", want.pos_z, got.pos_z);
         compare_field("peak", want.peak, got.peak);
         compare_field("last_of_volume", want.last_of_volume, got.last_of_volume);
      endfunction

      function int unsigned pending();
         return peaks_due.size();
      endfunction

      function bit at_plane_start();
         return x_pos == 0 && y_pos == 0 && t_pos == 0;
      endfunction

      function bit at_volume_start();
         return at_plane_start() && z_pos == 0;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [15:0]           req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_pos_x;
   logic [7:0]            rsp_pos_y;
   logic [15:0]           rsp_pos_z;
   logic [15:0]           rsp_peak;
   logic                  rsp_last_of_volume;
   int unsigned           cycle_count = 0;

   peak_projection_checker projection = new();

   abs_max_projection_time_top u_top (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_pos_z          (rsp_pos_z),
      .rsp_peak           (rsp_peak),
      .rsp_last_of_volume (rsp_last_of_volume)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Random idling for both channels, switched off in one long window.
   function automatic bit take_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
      return $urandom_range(99, 0) < 24;
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(9, 0))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_size(int unsigned hi);
      if ($urandom_range(19, 0) == 0) return 0;
      return $urandom_range(hi, 1);
   endfunction

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result receiver with random stalls.
   always @(posedge clock) begin
      rsp_ready <= !reset && !take_break();
   end

   // Every result transfer is checked against the oldest peak due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         projection.check_result({rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_peak,
                                  rsp_last_of_volume});
   end

   // Offers one sample, with an optional gap first, and notes it once the transfer happens.
   task automatic send_sample(input logic [15:0] value);
      if (take_break()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (take_break());
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      projection.note_sample(value);
   endtask

   // One register write in setup and access cycles; psel stays high for a following write.
   task automatic write_register(cfg_index_type index, int unsigned value, bit dirty);
      logic [CSR_DATA_W-1:0] data;
      int unsigned           width;
      width = (index == CFG_SIZE_X || index == CFG_SIZE_Y) ? 9 : 16;
      data = value;
      if (dirty) data = data | (($urandom >> width) << width);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * int'(index));
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      projection.set_register(index, data);
      penable <= 1'b0;
   endtask

   // Waits for the block to go idle, then rewrites the sizes. The plane sizes are
   // only touched at the start of a plane, so no store entry is read before it is written.
   task automatic configure(int unsigned nx, int unsigned ny, int unsigned nt, int unsigned nz,
                            bit plane_too, bit dirty);
      req_valid <= 1'b0;
      while (projection.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (plane_too) begin
         write_register(CFG_SIZE_X, nx, dirty);
         write_register(CFG_SIZE_Y, ny, dirty);
      end
      write_register(CFG_SAMPLES, nt, dirty);
      write_register(CFG_SLICES, nz, dirty);
      psel <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_volumes();
      do send_sample(random_sample()); while (!projection.at_volume_start());
   endtask

   initial begin
      logic [15:0] opening [12];
      int unsigned random_sent;
      int unsigned mode;
      int unsigned count;
      bit          whole;

      // Two slices of a 2x1 plane, three time samples each: full-scale values on the first
      // slice, a smaller start at x=0 on the second so the first-sample overwrite shows.
      opening = '{16'h8000, 16'h0000, 16'h0001, 16'h7FFF, 16'hFFFF, 16'hFFFE,
                  16'h0005, 16'h8001, 16'h0000, 16'h0000, 16'h0003, 16'h0001};
      random_sent = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(2, 1, 3, 2, 1'b0 == 1'b0, 1'b0);
      foreach (opening[i]) send_sample(opening[i]);

      // Trace length cut below the time counter mid-trace, then the slice count cut
      // below the z counter mid-volume.
      send_sample(16'h0100);
      send_sample(16'h0200);
      send_sample(16'hFF00);
      configure(0, 0, 1, 2, 1'b0, 1'b0);
      send_sample(16'h0050);
      configure(0, 0, 1, 1, 1'b0, 1'b0);
      send_sample(16'h1234);
      send_sample(16'hC000);

      // All sizes zero, used as one.
      configure(0, 0, 0, 0, 1'b1, 1'b0);
      send_sample(16'h8000);

      // Out-of-range row size clamped to a full row, written with junk upper bits.
      configure(511, 1, 1, 1, 1'b1, 1'b1);
      send_volumes();

      // Largest trace and slice counts, entered and then cut short: the trace length
      // drops below the time counter, then the slice count below the z counter.
      configure(1, 1, 65535, 65535, 1'b1, 1'b0);
      repeat (4) send_sample(random_sample());
      configure(0, 0, 1, 65535, 1'b0, 1'b0);
      repeat (3) send_sample(random_sample());
      configure(0, 0, 1, 1, 1'b0, 1'b0);
      send_sample(random_sample());

      // Random small volumes: mostly whole volumes, some whole planes, some cut short.
      while (random_sent < RANDOM_ITEMS) begin
         whole = projection.at_plane_start();
         configure(pick_size(6), pick_size(6), pick_size(5), pick_size(4), whole,
                   $urandom_range(3, 0) == 0);
         mode = $urandom_range(9, 0);
         count = $urandom_range(30, 1);
         do begin
            send_sample(random_sample());
            random_sent++;
            count--;
         end while (!(mode < 7 ? projection.at_volume_start() :
                      mode < 9 ? projection.at_plane_start() : count == 0));
      end

      // Drain the remaining results.
      req_valid <= 1'b0;
      while (projection.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (projection.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
